### hw/rtl/bir_pkg.sv
package bir_pkg;

    localparam int COORD_W     = 12;
    localparam int STEP_W      = 26;
    localparam int SIZE_W      = 10;
    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int CFG_DATA_W  = 26;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_STEP        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_STEP        = 2'd3;

    localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RESET  = 10'd512;
    localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RESET = 10'd512;
    localparam logic [STEP_W-1:0] X_STEP_RESET        = 26'd65536;
    localparam logic [STEP_W-1:0] Y_STEP_RESET        = 26'd65536;

    typedef struct packed {
        logic              mode;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [CHAN_W-1:0]  pixel_red;
        logic [CHAN_W-1:0]  pixel_green;
        logic [CHAN_W-1:0]  pixel_blue;
    } in_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } out_word_t;

    typedef struct packed {
        logic [SIZE_W-1:0] source_width;
        logic [SIZE_W-1:0] source_height;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
    } cfg_t;

endpackage

### hw/rtl/bir_front.sv
module bir_front #(
    parameter int MAX_SOURCE_DIM = 512,
    parameter int FRACTION_BITS  = 16,
    parameter int WEIGHT_BITS    = 8,
    localparam int AW    = $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM),
    localparam int WW    = 2 * WEIGHT_BITS + 1,
    localparam int CMD_W = 1 + 4 * AW + 4 * WW + bir_pkg::PIXEL_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bir_pkg::in_word_t   s_word,
    input  bir_pkg::cfg_t       cfg,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output logic [CMD_W-1:0]    cmd_data
);

    localparam int DIM_BITS = $clog2(MAX_SOURCE_DIM);
    localparam int PROD_W   = bir_pkg::COORD_W + bir_pkg::STEP_W;
    localparam int WHOLE_W  = PROD_W - FRACTION_BITS;
    localparam int SZ_W     = (DIM_BITS + 1 > bir_pkg::SIZE_W) ? DIM_BITS + 1 : bir_pkg::SIZE_W;
    localparam logic [AW-1:0] MAX_A = AW'(MAX_SOURCE_DIM);

    typedef struct packed {
        logic [DIM_BITS-1:0]    lo;
        logic [DIM_BITS-1:0]    hi;
        logic [WEIGHT_BITS-1:0] wt;
    } split_t;

    typedef struct packed {
        logic                               is_load;
        logic [3:0][AW-1:0]                 addr;
        logic [3:0][WW-1:0]                 wt;
        logic [bir_pkg::PIXEL_W-1:0]        rgb;
    } cmd_t;

    function automatic split_t split_coord(input logic [PROD_W-1:0] scaled,
                                           input logic [bir_pkg::SIZE_W-1:0] size);
        logic [WHOLE_W-1:0]                   whole;
        logic [FRACTION_BITS+WEIGHT_BITS-1:0] frac_ext;
        logic [SZ_W-1:0]                      eff;
        logic [SZ_W-1:0]                      last;
        logic [DIM_BITS-1:0]                  base;
        split_t                               r;
        whole    = scaled[PROD_W-1:FRACTION_BITS];
        frac_ext = {scaled[FRACTION_BITS-1:0], WEIGHT_BITS'(0)};
        if (size == '0) begin
            eff = SZ_W'(1);
        end else if (SZ_W'(size) > SZ_W'(MAX_SOURCE_DIM)) begin
            eff = SZ_W'(MAX_SOURCE_DIM);
        end else begin
            eff = SZ_W'(size);
        end
        last = eff - SZ_W'(1);
        base = (whole > WHOLE_W'(last)) ? last[DIM_BITS-1:0] : whole[DIM_BITS-1:0];
        r.lo = base;
        r.hi = (SZ_W'(base) >= last) ? base : base + DIM_BITS'(1);
        r.wt = frac_ext[FRACTION_BITS+WEIGHT_BITS-1 -: WEIGHT_BITS];
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [DIM_BITS-1:0] x,
                                              input logic [DIM_BITS-1:0] y);
        logic [AW-1:0] xa;
        logic [AW-1:0] ya;
        logic [AW-1:0] r;
        xa = AW'(x);
        ya = AW'(y);
        r  = ya * MAX_A + xa;
        return r;
    endfunction

    logic                  a_valid_reg, a_valid_next;
    bir_pkg::in_word_t     a_word_reg, a_word_next;
    logic [PROD_W-1:0]     a_sx_reg, a_sx_next;
    logic [PROD_W-1:0]     a_sy_reg, a_sy_next;

    split_t                sx_split, sy_split;
    logic                  load_in_range;
    logic                  s_accept;
    logic [WEIGHT_BITS:0]  sfx, sfy;
    logic [2*WEIGHT_BITS+1:0] wfull [4];
    logic [DIM_BITS-1:0]   load_x, load_y;
    cmd_t                  cmd;

    assign s_ready  = !a_valid_reg || !cmd_valid || cmd_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        a_valid_next = s_ready ? s_accept : a_valid_reg;
        a_word_next  = a_word_reg;
        a_sx_next    = a_sx_reg;
        a_sy_next    = a_sy_reg;
        if (s_accept) begin
            a_word_next = s_word;
            a_sx_next   = s_word.coord_x * cfg.x_step;
            a_sy_next   = s_word.coord_y * cfg.y_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_word_reg <= a_word_next;
        a_sx_reg   <= a_sx_next;
        a_sy_reg   <= a_sy_next;
    end

    // classify: drop loads outside the store, split requests into taps
    always_comb begin
        load_in_range = ({1'b0, a_word_reg.coord_x} < (bir_pkg::COORD_W + 1)'(MAX_SOURCE_DIM))
                     && ({1'b0, a_word_reg.coord_y} < (bir_pkg::COORD_W + 1)'(MAX_SOURCE_DIM));
        load_x   = a_word_reg.coord_x[DIM_BITS-1:0];
        load_y   = a_word_reg.coord_y[DIM_BITS-1:0];
        sx_split = split_coord(a_sx_reg, cfg.source_width);
        sy_split = split_coord(a_sy_reg, cfg.source_height);
        sfx      = {1'b1, WEIGHT_BITS'(0)} - {1'b0, sx_split.wt};
        sfy      = {1'b1, WEIGHT_BITS'(0)} - {1'b0, sy_split.wt};
        wfull[0] = sfx * sfy;
        wfull[1] = {1'b0, sx_split.wt} * sfy;
        wfull[2] = sfx * {1'b0, sy_split.wt};
        wfull[3] = {1'b0, sx_split.wt} * {1'b0, sy_split.wt};

        cmd.is_load = (a_word_reg.mode == bir_pkg::MODE_LOAD);
        cmd.rgb     = {a_word_reg.pixel_red, a_word_reg.pixel_green, a_word_reg.pixel_blue};
        if (cmd.is_load) begin
            for (int t = 0; t < 4; t++) begin
                cmd.addr[t] = addr_of(load_x, load_y);
                cmd.wt[t]   = '0;
            end
        end else begin
            cmd.addr[0] = addr_of(sx_split.lo, sy_split.lo);
            cmd.addr[1] = addr_of(sx_split.hi, sy_split.lo);
            cmd.addr[2] = addr_of(sx_split.lo, sy_split.hi);
            cmd.addr[3] = addr_of(sx_split.hi, sy_split.hi);
            for (int t = 0; t < 4; t++) begin
                cmd.wt[t] = wfull[t][WW-1:0];
            end
        end
    end

    assign cmd_valid = a_valid_reg && (!cmd.is_load || load_in_range);
    assign cmd_data  = cmd;

endmodule

### hw/rtl/bir_queue.sv
module bir_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = $clog2(bir_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bir_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [bir_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(bir_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/bir_back.sv
module bir_back #(
    parameter int MAX_SOURCE_DIM = 512,
    parameter int WEIGHT_BITS    = 8,
    localparam int AW    = $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM),
    localparam int WW    = 2 * WEIGHT_BITS + 1,
    localparam int CMD_W = 1 + 4 * AW + 4 * WW + bir_pkg::PIXEL_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  logic [CMD_W-1:0]   cmd_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bir_pkg::out_word_t m_word
);

    localparam int DEPTH = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
    localparam int ACC_W = bir_pkg::CHAN_W + WW;
    localparam int Q_W   = ACC_W - 2 * WEIGHT_BITS;

    typedef struct packed {
        logic                               is_load;
        logic [3:0][AW-1:0]                 addr;
        logic [3:0][WW-1:0]                 wt;
        logic [bir_pkg::PIXEL_W-1:0]        rgb;
    } cmd_t;

    logic [bir_pkg::PIXEL_W-1:0] mem [DEPTH];

    cmd_t                        cmd;
    logic [1:0]                  tap_reg, tap_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        rd_last_reg, rd_first_reg;
    logic [WW-1:0]               rd_wt_reg;
    logic [bir_pkg::PIXEL_W-1:0] rd_data_reg;
    logic [ACC_W-1:0]            acc_reg [3];
    logic                        m_valid_reg, m_valid_next;
    bir_pkg::out_word_t          m_word_reg;

    logic                        stall, go, issue_read, out_we;
    logic [AW-1:0]               mem_addr;
    logic [ACC_W-1:0]            prod [3];
    logic [ACC_W-1:0]            sum [3];
    logic [Q_W-1:0]              q [3];
    logic [bir_pkg::CHAN_W-1:0]  res [3];

    assign cmd = cmd_t'(cmd_data);

    // hold the whole back end while a finished pixel cannot reach the output
    assign stall      = rd_valid_reg && rd_last_reg && m_valid_reg && !m_ready;
    assign go         = cmd_valid && !stall;
    assign issue_read = go && !cmd.is_load;
    assign cmd_pop    = go && (cmd.is_load || tap_reg == 2'd3);
    assign mem_addr   = cmd.is_load ? cmd.addr[0] : cmd.addr[tap_reg];
    assign out_we     = rd_valid_reg && rd_last_reg && !stall;

    always_comb begin
        tap_next      = issue_read ? tap_reg + 2'd1 : tap_reg;
        rd_valid_next = stall ? rd_valid_reg : issue_read;
        m_valid_next  = out_we ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = ACC_W'(rd_data_reg[bir_pkg::PIXEL_W-1-c*bir_pkg::CHAN_W -: bir_pkg::CHAN_W])
                    * ACC_W'(rd_wt_reg);
            sum[c]  = (rd_first_reg ? '0 : acc_reg[c]) + prod[c];
            q[c]    = sum[c][ACC_W-1:2*WEIGHT_BITS];
            res[c]  = (q[c] > Q_W'(255)) ? 8'hFF : q[c][bir_pkg::CHAN_W-1:0];
        end
    end

    // single port: one write or one read a cycle
    always_ff @(posedge aclk) begin
        if (go) begin
            if (cmd.is_load) begin
                mem[mem_addr] <= cmd.rgb;
            end else begin
                rd_data_reg <= mem[mem_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            tap_reg      <= tap_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_read) begin
            rd_last_reg  <= (tap_reg == 2'd3);
            rd_first_reg <= (tap_reg == 2'd0);
            rd_wt_reg    <= cmd.wt[tap_reg];
        end
        if (rd_valid_reg && !stall) begin
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= sum[c];
            end
        end
        if (out_we) begin
            m_word_reg.out_red   <= res[0];
            m_word_reg.out_green <= res[1];
            m_word_reg.out_blue  <= res[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

### hw/rtl/bilinear_image_resize.sv
// Bilinear image scaler with an internal frame store.
// Input channel (s_valid/s_ready/s_word): a load word (mode 0) writes one RGB pixel
// at (coord_x, coord_y) into the store; loads outside the store are dropped. A
// request word (mode 1) names a destination pixel and yields one output word.
// Output channel (m_valid/m_ready/m_word): interpolated RGB, in request order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (source width,
// source height, x step, y step in unsigned 10.16). The user must write them only
// while the block is idle; the block itself does not enforce this.
// The frame store takes one load per cycle unless the output stalls; a request
// needs four neighbour reads, one after another, through its single port.
// A front stage scales and classifies words and pushes them into a 4-deep queue;
// the back end drains it, so input keeps flowing while the back end works.
// Reset clears control state and the registers to 512, 512, 1.0, 1.0; the frame
// store is not cleared, so requests must only touch pixels that were loaded.
// A stalled receiver holds the result in the output register; the back end
// freezes once its next result is done; input is accepted until the queue fills.
module bilinear_image_resize #(
    parameter int MAX_SOURCE_DIM = 512,
    parameter int FRACTION_BITS  = 16,
    parameter int WEIGHT_BITS    = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bir_pkg::in_word_t                   s_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bir_pkg::out_word_t                  m_word,
    input  logic                                cfg_we,
    input  logic [bir_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int AW    = $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM);
    localparam int WW    = 2 * WEIGHT_BITS + 1;
    localparam int CMD_W = 1 + 4 * AW + 4 * WW + bir_pkg::PIXEL_W;

    bir_pkg::cfg_t      cfg_reg, cfg_next;

    logic               front_cmd_valid;
    logic               front_cmd_ready;
    logic [CMD_W-1:0]   front_cmd_data;
    logic               back_cmd_valid;
    logic               back_cmd_pop;
    logic [CMD_W-1:0]   back_cmd_data;

    // register writes: truncate the data word to each register's width
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                bir_pkg::CFG_SOURCE_WIDTH: begin
                    cfg_next.source_width = cfg_wdata[bir_pkg::SIZE_W-1:0];
                end
                bir_pkg::CFG_SOURCE_HEIGHT: begin
                    cfg_next.source_height = cfg_wdata[bir_pkg::SIZE_W-1:0];
                end
                bir_pkg::CFG_X_STEP: begin
                    cfg_next.x_step = cfg_wdata[bir_pkg::STEP_W-1:0];
                end
                bir_pkg::CFG_Y_STEP: begin
                    cfg_next.y_step = cfg_wdata[bir_pkg::STEP_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_width  <= bir_pkg::SOURCE_WIDTH_RESET;
            cfg_reg.source_height <= bir_pkg::SOURCE_HEIGHT_RESET;
            cfg_reg.x_step        <= bir_pkg::X_STEP_RESET;
            cfg_reg.y_step        <= bir_pkg::Y_STEP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: multiply coordinates by the steps, clamp, weight, form addresses
    bir_front #(
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .FRACTION_BITS  (FRACTION_BITS),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .cfg       (cfg_reg),
        .cmd_valid (front_cmd_valid),
        .cmd_ready (front_cmd_ready),
        .cmd_data  (front_cmd_data)
    );

    // decouple the front from the memory-bound back end
    bir_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_cmd_valid),
        .push_ready (front_cmd_ready),
        .push_data  (front_cmd_data),
        .pop_valid  (back_cmd_valid),
        .pop_ready  (back_cmd_pop),
        .pop_data   (back_cmd_data)
    );

    // back: frame store writes, four tap reads, blend, output register
    bir_back #(
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_cmd_valid),
        .cmd_pop   (back_cmd_pop),
        .cmd_data  (back_cmd_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    // a command blocked by a full queue stays put until the queue takes it
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        front_cmd_valid && !front_cmd_ready |=> front_cmd_valid && $stable(front_cmd_data))
        else $error("front command changed while the queue was full");

    // the input only backs up because the queue is full
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> front_cmd_valid && !front_cmd_ready)
        else $error("input stalled without a blocked front command");

    // the back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        back_cmd_pop |-> back_cmd_valid)
        else $error("back end popped an empty queue");

endmodule

### test/resize_checker.sv
module resize_checker
    import bir_pkg::*;
#(
    parameter int MAX_SOURCE_DIM = 512,
    parameter int FRACTION_BITS  = 16,
    parameter int WEIGHT_BITS    = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_word_t               s_word,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_word_t              m_word,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     pending,
    output int                     failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_SOURCE_DIM * MAX_SOURCE_DIM;

    bit [PIXEL_W-1:0] frame_copy [STORE_DEPTH];
    cfg_t             geometry;
    out_word_t        expected_pixels [$];
    int               result_index = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: result %0d: %s", $time, result_index, what);
        failures++;
    endtask

    task automatic check_channel(input string name, input logic [CHAN_W-1:0] got,
                                 input logic [CHAN_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        end
    endtask

    function automatic int unsigned effective_size(input bit [SIZE_W-1:0] size_reg);
        if (size_reg == 0) return 1;
        if (size_reg > MAX_SOURCE_DIM) return MAX_SOURCE_DIM;
        return 32'(size_reg);
    endfunction

    // Scale one coordinate, clamp both neighbours to the image, keep the weight.
    function automatic void scale_axis(input bit [COORD_W-1:0] coord,
                                       input bit [STEP_W-1:0] step,
                                       input bit [SIZE_W-1:0] size_reg,
                                       output int unsigned lo_idx,
                                       output int unsigned hi_idx,
                                       output longint unsigned weight);
        longint unsigned scaled, whole, frac, last;
        scaled = 64'(coord) * 64'(step);
        whole  = scaled >> FRACTION_BITS;
        frac   = scaled & ((64'd1 << FRACTION_BITS) - 1);
        if (WEIGHT_BITS <= FRACTION_BITS) begin
            weight = frac >> (FRACTION_BITS - WEIGHT_BITS);
        end else begin
            weight = frac << (WEIGHT_BITS - FRACTION_BITS);
        end
        weight &= (64'd1 << WEIGHT_BITS) - 1;
        last   = 64'(effective_size(size_reg)) - 1;
        lo_idx = 32'((whole > last) ? last : whole);
        hi_idx = (64'(lo_idx) + 1 > last) ? 32'(last) : lo_idx + 1;
    endfunction

    function automatic out_word_t blend_request(input bit [COORD_W-1:0] cx,
                                                input bit [COORD_W-1:0] cy);
        int unsigned      x0, x1, y0, y1;
        longint unsigned  fx, fy, full, acc;
        longint unsigned  share [4];
        bit [PIXEL_W-1:0] corner [4];
        bit [CHAN_W-1:0]  chan [3];
        out_word_t        blended;
        scale_axis(cx, geometry.x_step, geometry.source_width, x0, x1, fx);
        scale_axis(cy, geometry.y_step, geometry.source_height, y0, y1, fy);
        full      = 64'd1 << WEIGHT_BITS;
        corner[0] = frame_copy[y0 * MAX_SOURCE_DIM + x0];
        corner[1] = frame_copy[y0 * MAX_SOURCE_DIM + x1];
        corner[2] = frame_copy[y1 * MAX_SOURCE_DIM + x0];
        corner[3] = frame_copy[y1 * MAX_SOURCE_DIM + x1];
        share[0]  = (full - fx) * (full - fy);
        share[1]  = fx * (full - fy);
        share[2]  = (full - fx) * fy;
        share[3]  = fx * fy;
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int n = 0; n < 4; n++) begin
                acc += 64'(corner[n][PIXEL_W-1-CHAN_W*k -: CHAN_W]) * share[n];
            end
            acc >>= 2 * WEIGHT_BITS;
            chan[k] = (acc > 255) ? '1 : acc[CHAN_W-1:0];
        end
        blended.out_red   = chan[0];
        blended.out_green = chan[1];
        blended.out_blue  = chan[2];
        return blended;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            geometry.source_width  = SOURCE_WIDTH_RESET;
            geometry.source_height = SOURCE_HEIGHT_RESET;
            geometry.x_step        = X_STEP_RESET;
            geometry.y_step        = Y_STEP_RESET;
            expected_pixels.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  geometry.source_width  = cfg_wdata[SIZE_W-1:0];
                    CFG_SOURCE_HEIGHT: geometry.source_height = cfg_wdata[SIZE_W-1:0];
                    CFG_X_STEP:        geometry.x_step        = cfg_wdata[STEP_W-1:0];
                    CFG_Y_STEP:        geometry.y_step        = cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            // Compare outgoing words before queuing new requests from this edge.
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("output word %h with no request pending",
                                              m_word));
                end else begin
                    want = expected_pixels.pop_front();
                    check_channel("red", m_word.out_red, want.out_red);
                    check_channel("green", m_word.out_green, want.out_green);
                    check_channel("blue", m_word.out_blue, want.out_blue);
                end
                result_index++;
            end
            if (s_valid && s_ready) begin
                if (s_word.mode == MODE_LOAD) begin
                    if (s_word.coord_x < MAX_SOURCE_DIM && s_word.coord_y < MAX_SOURCE_DIM) begin
                        frame_copy[s_word.coord_y * MAX_SOURCE_DIM + s_word.coord_x] =
                            {s_word.pixel_red, s_word.pixel_green, s_word.pixel_blue};
                    end
                end else begin
                    expected_pixels.push_back(blend_request(s_word.coord_x, s_word.coord_y));
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

### test/tb_bilinear_image_resize.sv
module tb_bilinear_image_resize;
    timeunit 1ns;
    timeprecision 1ps;

    import bir_pkg::*;

    localparam int MAX_SOURCE_DIM = 512;
    localparam int FRACTION_BITS  = 16;
    localparam int WEIGHT_BITS    = 8;

    localparam int IDLE_PERCENT   = 25;
    localparam int ITEM_TARGET    = 900;
    // Long enough for the queue and the pipeline to drain, with margin.
    localparam int SETTLE_CYCLES  = 40;
    localparam int CYCLE_LIMIT    = 300000;
    localparam logic [STEP_W-1:0] MAX_STEP = 26'd33554432;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_word_t               s_word    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_word_t              m_word;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SOURCE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int pending;
    int failures;
    int cycle_count  = 0;
    int sent_items   = 0;
    bit steady       = 1'b0;    // set: neither side idles

    bilinear_image_resize #(
        .MAX_SOURCE_DIM(MAX_SOURCE_DIM),
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_dut (.*);

    resize_checker #(
        .MAX_SOURCE_DIM(MAX_SOURCE_DIM),
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel about a quarter of the time, never while steady.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bilinear_image_resize regression: fail");
            $finish;
        end
    end

    // Offer one word, idling first at random; return on the accepting edge with
    // valid still high so a following word goes out back to back.
    task automatic send_word(input in_word_t word);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= word;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    task automatic send_load(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
                             input bit [PIXEL_W-1:0] rgb);
        in_word_t word;
        word.mode    = MODE_LOAD;
        word.coord_x = x;
        word.coord_y = y;
        {word.pixel_red, word.pixel_green, word.pixel_blue} = rgb;
        send_word(word);
    endtask

    // Pixel fields of a request are don't-care; fill them with noise.
    task automatic send_request(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y);
        in_word_t word;
        word.mode    = MODE_REQUEST;
        word.coord_x = x;
        word.coord_y = y;
        {word.pixel_red, word.pixel_green, word.pixel_blue} = PIXEL_W'($urandom);
        send_word(word);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Only called with the block idle.
    task automatic set_geometry(input int unsigned width_reg, input int unsigned height_reg,
                                input bit [STEP_W-1:0] x_step, input bit [STEP_W-1:0] y_step);
        write_reg(CFG_SOURCE_WIDTH, CFG_DATA_W'(width_reg));
        write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(height_reg));
        write_reg(CFG_X_STEP, CFG_DATA_W'(x_step));
        write_reg(CFG_Y_STEP, CFG_DATA_W'(y_step));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the input until every result is out, then let queued loads retire.
    // Poll on the falling edge so the checker's count is settled.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) return 0;
        if (roll == 1) return $urandom_range(9, 16);
        return $urandom_range(1, 8);
    endfunction

    function automatic bit [STEP_W-1:0] pick_step();
        int unsigned roll;
        roll = $urandom_range(9);
        case (roll)
            0:       return '0;
            1:       return MAX_STEP;
            2:       return STEP_W'($urandom_range(MAX_STEP));
            3:       return 26'h0FFFF;
            default: return STEP_W'($urandom_range(26'h30000, 26'h02000));
        endcase
    endfunction

    // Upper bound for destination coordinates: just past the image edge, capped at 4095.
    function automatic int unsigned dest_reach(input int unsigned size,
                                               input bit [STEP_W-1:0] step);
        longint unsigned reach;
        if (step == 0) return 15;
        reach = ((64'(size) << FRACTION_BITS) / step) + 1;
        return (reach > 4095) ? 4095 : 32'(reach);
    endfunction

    initial begin
        int unsigned     width_reg, height_reg, eff_w, eff_h, x_reach, y_reach;
        bit [STEP_W-1:0] x_step, y_step;
        int              phase, body_items, roll, reach_pos;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a 2x2 image with extreme channel values, an almost-one
        // horizontal weight and a half vertical weight.
        set_geometry(2, 2, 26'h0FFFF, 26'h08000);
        send_load(0, 0, 24'hFF00AA);
        send_load(1, 0, 24'h00FF55);
        send_load(0, 1, 24'h55AAFF);
        send_load(1, 1, 24'hAA5500);
        // Drop loads that fall outside the store; the far corner still lands.
        send_load(512, 0, 24'hFFFFFF);
        send_load(0, 4095, 24'hFFFFFF);
        send_load(4095, 4095, 24'hFFFFFF);
        send_load(511, 511, 24'h123456);
        send_request(0, 0);
        send_request(1, 1);
        send_request(1, 0);
        send_request(0, 1);
        send_request(2, 3);
        // Coordinates far past the image saturate to the last row and column.
        send_request(4095, 4095);
        send_request(4095, 0);
        wait_for_results();

        // Random phases. The first two pin the size and step registers to their
        // extremes (out-of-range sizes included) and load only the pixels a step
        // of 512.0 can reach; every later phase first loads its whole effective
        // image, so no request touches an unwritten pixel.
        phase = 0;
        while (phase < 2 || sent_items < ITEM_TARGET) begin
            steady = (phase >= 4 && phase < 7);
            case (phase)
                0: begin
                    width_reg = 1023; height_reg = 0;
                    x_step = MAX_STEP; y_step = '0;
                end
                1: begin
                    width_reg = 0; height_reg = 512;
                    x_step = '0; y_step = MAX_STEP;
                end
                default: begin
                    width_reg = pick_size(); height_reg = pick_size();
                    x_step = pick_step(); y_step = pick_step();
                end
            endcase
            set_geometry(width_reg, height_reg, x_step, y_step);
            eff_w = (width_reg == 0) ? 1 :
                    (width_reg > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : width_reg;
            eff_h = (height_reg == 0) ? 1 :
                    (height_reg > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : height_reg;

            if (phase < 2) begin
                // Only the first two and the last pixel of the long axis are reachable.
                for (int k = 0; k < 3; k++) begin
                    reach_pos = (k == 2) ? MAX_SOURCE_DIM - 1 : k;
                    if (phase == 0) begin
                        send_load(COORD_W'(reach_pos), '0, PIXEL_W'($urandom));
                    end else begin
                        send_load('0, COORD_W'(reach_pos), PIXEL_W'($urandom));
                    end
                end
            end else begin
                for (int y = 0; y < eff_h; y++) begin
                    for (int x = 0; x < eff_w; x++) begin
                        send_load(COORD_W'(x), COORD_W'(y), PIXEL_W'($urandom));
                    end
                end
            end

            x_reach    = dest_reach(eff_w, x_step);
            y_reach    = dest_reach(eff_h, y_step);
            body_items = $urandom_range(12, 40);
            for (int i = 0; i < body_items; i++) begin
                // Now and then drain completely mid-phase.
                if (phase % 7 == 3 && i == body_items / 2) wait_for_results();
                roll = $urandom_range(99);
                if (roll < 65) begin
                    if ($urandom_range(3) != 0) begin
                        send_request(COORD_W'($urandom_range(x_reach)),
                                     COORD_W'($urandom_range(y_reach)));
                    end else begin
                        send_request(COORD_W'($urandom_range(4095)),
                                     COORD_W'($urandom_range(4095)));
                    end
                end else if (roll < 90) begin
                    // Overwrite a pixel of the image behind queued requests.
                    send_load(COORD_W'($urandom_range(eff_w - 1)),
                              COORD_W'($urandom_range(eff_h - 1)), PIXEL_W'($urandom));
                end else if ($urandom_range(1) == 0) begin
                    send_load(COORD_W'($urandom_range(4095, MAX_SOURCE_DIM)),
                              COORD_W'($urandom_range(4095)), PIXEL_W'($urandom));
                end else begin
                    send_load(COORD_W'($urandom_range(4095)),
                              COORD_W'($urandom_range(4095, MAX_SOURCE_DIM)),
                              PIXEL_W'($urandom));
                end
            end
            wait_for_results();
            phase++;
        end
        steady = 1'b0;

        if (failures == 0) begin
            $display("bilinear_image_resize regression: pass");
        end else begin
            $display("bilinear_image_resize regression: fail");
        end
        $finish;
    end

endmodule
